@@ src/d2c_pkg.sv @@
package d2c_pkg;

	localparam int COLOR_WIDTH  = 1920;
	localparam int COLOR_HEIGHT = 1080;

	localparam int BP_NUM_W = 40;
	localparam int BP_DEN_W = 17;
	localparam int PJ_NUM_W = 60;
	localparam int PJ_DEN_W = 44;

	typedef enum logic [2:0] {
		REG_DEPTH_FOCAL   = 3'd0,
		REG_DEPTH_CENTER  = 3'd1,
		REG_COLOR_FOCAL   = 3'd2,
		REG_COLOR_CENTER  = 3'd3,
		REG_ROTATION_ROW0 = 3'd4,
		REG_ROTATION_ROW1 = 3'd5,
		REG_ROTATION_ROW2 = 3'd6,
		REG_TRANSLATION   = 3'd7
	} reg_index_t;

	localparam logic [31:0] DEPTH_FOCAL_RST   = 32'd379983513;
	localparam logic [31:0] DEPTH_CENTER_RST  = 32'd214962100;
	localparam logic [31:0] COLOR_FOCAL_RST   = 32'd1108296214;
	localparam logic [31:0] COLOR_CENTER_RST  = 32'd559233747;
	localparam logic [47:0] ROTATION_ROW0_RST = 48'd1069457096701;
	localparam logic [47:0] ROTATION_ROW1_RST = 48'd281089503330150;
	localparam logic [47:0] ROTATION_ROW2_RST = 48'd70360160075527;
	localparam logic [47:0] TRANSLATION_RST   = 48'd281234458018691;

	typedef struct packed {
		logic [8:0]  pixel_col;
		logic [8:0]  pixel_row;
		logic [15:0] depth_mm;
	} pixel_t;

	typedef struct packed {
		logic               point_valid;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic signed [15:0] color_col;
		logic signed [15:0] color_row;
		logic               in_color_image;
	} result_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

@@ src/d2c_stream_if.sv @@
interface d2c_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/d2c_cfg_if.sv @@
interface d2c_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ src/depth_to_color_registration_unit.sv @@
// Throughput: one pixel per cycle unless the result side stalls; two
// pairs of bit-per-stage divider pipelines (back-projection and color
// projection) set the depth.
// A stall on the result side holds the whole pipeline in place.
// Reset: asynchronous, active low; clears valid bits and loads the
// built-in calibration into all calibration registers.
module depth_to_color_registration_unit #(
	parameter int COLOR_WIDTH  = d2c_pkg::COLOR_WIDTH,
	parameter int COLOR_HEIGHT = d2c_pkg::COLOR_HEIGHT
) (
	input logic        clk,
	input logic        arst_n,
	d2c_stream_if.sink   pixel,
	d2c_stream_if.source point,
	d2c_cfg_if.sink      cfg
);

	localparam int BNW = d2c_pkg::BP_NUM_W;
	localparam int BDW = d2c_pkg::BP_DEN_W;
	localparam int PNW = d2c_pkg::PJ_NUM_W;
	localparam int PDW = d2c_pkg::PJ_DEN_W;

	logic [31:0] depth_focal_q, depth_center_q, color_focal_q, color_center_q;
	logic [47:0] rot_row_q [3];
	logic [47:0] translation_q;

	logic adv;

	assign adv         = !point.valid || point.ready;
	assign pixel.ready = adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_focal_q  <= d2c_pkg::DEPTH_FOCAL_RST;
			depth_center_q <= d2c_pkg::DEPTH_CENTER_RST;
			color_focal_q  <= d2c_pkg::COLOR_FOCAL_RST;
			color_center_q <= d2c_pkg::COLOR_CENTER_RST;
			rot_row_q[0]   <= d2c_pkg::ROTATION_ROW0_RST;
			rot_row_q[1]   <= d2c_pkg::ROTATION_ROW1_RST;
			rot_row_q[2]   <= d2c_pkg::ROTATION_ROW2_RST;
			translation_q  <= d2c_pkg::TRANSLATION_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				d2c_pkg::REG_DEPTH_FOCAL:   depth_focal_q  <= cfg.data[31:0];
				d2c_pkg::REG_DEPTH_CENTER:  depth_center_q <= cfg.data[31:0];
				d2c_pkg::REG_COLOR_FOCAL:   color_focal_q  <= cfg.data[31:0];
				d2c_pkg::REG_COLOR_CENTER:  color_center_q <= cfg.data[31:0];
				d2c_pkg::REG_ROTATION_ROW0: rot_row_q[0]   <= cfg.data;
				d2c_pkg::REG_ROTATION_ROW1: rot_row_q[1]   <= cfg.data;
				d2c_pkg::REG_ROTATION_ROW2: rot_row_q[2]   <= cfg.data;
				d2c_pkg::REG_TRANSLATION:   translation_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// stage 1: pixel offset from depth principal point, 1/16 px
	logic               v_s1;
	logic signed [17:0] dx_s1, dy_s1;
	logic [15:0]        d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= $signed({5'b0, pixel.data.pixel_col, 4'b0})
				- $signed({2'b0, depth_center_q[15:0]});
			dy_s1 <= $signed({5'b0, pixel.data.pixel_row, 4'b0})
				- $signed({2'b0, depth_center_q[31:16]});
			d_s1  <= pixel.data.depth_mm;
		end
	end

	// stage 2: rounding numerators 2n + f
	logic                  v_s2;
	logic signed [34:0]    prd_x, prd_y;
	logic signed [BNW-1:0] nx_s2, ny_s2;
	logic [15:0]           d_s2;
	logic                  dz_s2;

	assign prd_x = dx_s1 * $signed({1'b0, d_s1});
	assign prd_y = dy_s1 * $signed({1'b0, d_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2 <= {prd_x, 5'b0} + {24'b0, depth_focal_q[15:0]};
			ny_s2 <= {prd_y, 5'b0} + {24'b0, depth_focal_q[31:16]};
			d_s2  <= d_s1;
			dz_s2 <= d_s1 == 16'd0;
		end
	end

	logic                  vx_dv, vy_dv;
	logic signed [BNW-1:0] qx_dv, qy_dv;
	logic [15:0]           d_dv;
	logic                  dz_dv;

	d2c_floor_div #(.NW(BNW), .DW(BDW), .TW(16)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.num      (nx_s2),
		.den      ({depth_focal_q[15:0], 1'b0}),
		.tag_in   (d_s2),
		.out_valid(vx_dv),
		.quo      (qx_dv),
		.tag_out  (d_dv)
	);

	d2c_floor_div #(.NW(BNW), .DW(BDW), .TW(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.num      (ny_s2),
		.den      ({depth_focal_q[31:16], 1'b0}),
		.tag_in   (dz_s2),
		.out_valid(vy_dv),
		.quo      (qy_dv),
		.tag_out  (dz_dv)
	);

	// stage 3: rotation products
	logic signed [37:0] p_c [3];
	logic signed [15:0] rot_c [3][3];
	logic signed [15:0] tr_c [3];

	always_comb begin
		p_c[0] = (depth_focal_q[15:0] == 16'd0) ? 38'sd0 : qx_dv[37:0];
		p_c[1] = (depth_focal_q[31:16] == 16'd0) ? 38'sd0 : qy_dv[37:0];
		p_c[2] = $signed({18'b0, d_dv, 4'b0});
		for (int i = 0; i < 3; i++) begin
			tr_c[i] = translation_q[16*i +: 16];
			for (int j = 0; j < 3; j++) begin
				rot_c[i][j] = rot_row_q[i][16*j +: 16];
			end
		end
	end

	logic               v_s3, dz_s3;
	logic signed [53:0] prd_s3 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vx_dv && vy_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_s3 <= dz_dv;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prd_s3[i][j] <= rot_c[i][j] * p_c[j];
				end
			end
		end
	end

	// stage 4: row sums
	logic               v_s4, dz_s4;
	logic signed [55:0] acc_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_s4 <= dz_s3;
			for (int i = 0; i < 3; i++) begin
				acc_s4[i] <= 56'(prd_s3[i][0]) + 56'(prd_s3[i][1]) + 56'(prd_s3[i][2]);
			end
		end
	end

	// stage 5: round by 2^14, add translation
	logic               v_s5, dz_s5;
	logic signed [41:0] q_s5 [3];
	logic signed [55:0] rnd_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = acc_s4[i] + 56'sd8192;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_s5 <= dz_s4;
			for (int i = 0; i < 3; i++) begin
				q_s5[i] <= 42'(rnd_c[i] >>> 14) + 42'(tr_c[i]);
			end
		end
	end

	// stage 6: point output, projection products
	logic               v_s6, dz_s6, pv_s6;
	logic signed [15:0] pt_s6 [3];
	logic signed [58:0] mu_s6, cu_s6, mv_s6, cv_s6;
	logic [PDW-1:0]     den_s6;
	logic signed [41:0] hr_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hr_c[i] = (q_s5[i] + 42'sd8) >>> 4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_s6  <= dz_s5;
			pv_s6  <= !dz_s5 && (q_s5[2] > 42'sd0);
			for (int i = 0; i < 3; i++) begin
				pt_s6[i] <= d2c_pkg::sat16(64'(hr_c[i]));
			end
			mu_s6  <= $signed({1'b0, color_focal_q[15:0]}) * q_s5[0];
			cu_s6  <= $signed({1'b0, color_center_q[15:0]}) * q_s5[2];
			mv_s6  <= $signed({1'b0, color_focal_q[31:16]}) * q_s5[1];
			cv_s6  <= $signed({1'b0, color_center_q[31:16]}) * q_s5[2];
			den_s6 <= {q_s5[2][39:0], 4'b0};
		end
	end

	// stage 7: projection numerators
	logic                  v_s7, dz_s7, pv_s7;
	logic signed [15:0]    pt_s7 [3];
	logic signed [PNW-1:0] nu_s7, nv_s7;
	logic [PDW-1:0]        den_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_s7  <= dz_s6;
			pv_s7  <= pv_s6;
			pt_s7  <= pt_s6;
			nu_s7  <= PNW'(mu_s6) + PNW'(cu_s6);
			nv_s7  <= PNW'(mv_s6) + PNW'(cv_s6);
			den_s7 <= den_s6;
		end
	end

	logic                  vu_dv, vv_dv;
	logic signed [PNW-1:0] u_dv, v_dv;
	logic [48:0]           ptag_dv;
	logic                  pv_dv;

	d2c_floor_div #(.NW(PNW), .DW(PDW), .TW(49)) u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.num      (nu_s7),
		.den      (den_s7),
		.tag_in   ({dz_s7, pt_s7[0], pt_s7[1], pt_s7[2]}),
		.out_valid(vu_dv),
		.quo      (u_dv),
		.tag_out  (ptag_dv)
	);

	d2c_floor_div #(.NW(PNW), .DW(PDW), .TW(1)) u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.num      (nv_s7),
		.den      (den_s7),
		.tag_in   (pv_s7),
		.out_valid(vv_dv),
		.quo      (v_dv),
		.tag_out  (pv_dv)
	);

	// result register
	d2c_pkg::result_t res_c, res_q;
	logic             out_v_q;
	logic             dz_f;

	always_comb begin
		dz_f = ptag_dv[48];
		res_c.point_valid = pv_dv;
		res_c.point_x     = dz_f ? 16'sd0 : ptag_dv[47:32];
		res_c.point_y     = dz_f ? 16'sd0 : ptag_dv[31:16];
		res_c.point_z     = dz_f ? 16'sd0 : ptag_dv[15:0];
		res_c.color_col   = pv_dv ? d2c_pkg::sat16(64'(u_dv)) : 16'sd0;
		res_c.color_row   = pv_dv ? d2c_pkg::sat16(64'(v_dv)) : 16'sd0;
		res_c.in_color_image = pv_dv
			&& (u_dv >= PNW'(0)) && (u_dv < $signed(PNW'(COLOR_WIDTH)))
			&& (v_dv >= PNW'(0)) && (v_dv < $signed(PNW'(COLOR_HEIGHT)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vu_dv && vv_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_c;
		end
	end

	assign point.valid = out_v_q;
	assign point.data  = res_q;

endmodule

@@ src/d2c_floor_div.sv @@
module d2c_floor_div #(
	parameter int NW = 40,
	parameter int DW = 17,
	parameter int TW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	input  logic [TW-1:0]        tag_in,
	output logic                 out_valid,
	output logic signed [NW-1:0] quo,
	output logic [TW-1:0]        tag_out
);

	localparam int MW = ((NW > DW) ? NW : DW) + 1;

	logic          v_q   [MW+1];
	logic          neg_q [MW+1];
	logic [DW-1:0] d_q   [MW+1];
	logic [MW-1:0] dv_q  [MW+1];
	logic [DW-1:0] rm_q  [MW+1];
	logic [TW-1:0] tg_q  [MW+1];

	logic [DW:0]   trial [MW];
	logic [DW:0]   diff  [MW];
	logic          ge    [MW];

	logic [MW-1:0] num_x;
	logic [MW-1:0] mag;

	logic                 out_v_q;
	logic signed [NW-1:0] quo_q;
	logic [TW-1:0]        tag_q;

	// floor for negative numerators: -ceil(|n| / d)
	always_comb begin
		num_x = MW'(num);
		mag   = num[NW-1] ? (~num_x + MW'(den)) : num_x;
	end

	always_comb begin
		for (int k = 0; k < MW; k++) begin
			trial[k] = {rm_q[k], dv_q[k][MW-1]};
			diff[k]  = trial[k] - {1'b0, d_q[k]};
			ge[k]    = trial[k] >= {1'b0, d_q[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= MW; k++) begin
				v_q[k] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int k = 0; k < MW; k++) begin
				v_q[k+1] <= v_q[k];
			end
			out_v_q <= v_q[MW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0] <= num[NW-1];
			d_q[0]   <= den;
			dv_q[0]  <= mag;
			rm_q[0]  <= '0;
			tg_q[0]  <= tag_in;
			for (int k = 0; k < MW; k++) begin
				neg_q[k+1] <= neg_q[k];
				d_q[k+1]   <= d_q[k];
				tg_q[k+1]  <= tg_q[k];
				dv_q[k+1]  <= {dv_q[k][MW-2:0], ge[k]};
				rm_q[k+1]  <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
			end
			quo_q <= neg_q[MW] ? NW'(~dv_q[MW] + 1'b1) : NW'(dv_q[MW]);
			tag_q <= tg_q[MW];
		end
	end

	assign out_valid = out_v_q;
	assign quo       = quo_q;
	assign tag_out   = tag_q;

endmodule

@@ test/depth_to_color_registration_unit_tb.sv @@
`timescale 1ns / 1ps

module depth_to_color_registration_unit_tb;

	localparam int LATENCY = 114;
	localparam int WATCHDOG_LIMIT = 4000;

	class registration_scoreboard;
		logic [47:0] cal [8];
		d2c_pkg::result_t expected_points [$];
		int mismatches;

		function new();
			cal[d2c_pkg::REG_DEPTH_FOCAL] = d2c_pkg::DEPTH_FOCAL_RST;
			cal[d2c_pkg::REG_DEPTH_CENTER] = d2c_pkg::DEPTH_CENTER_RST;
			cal[d2c_pkg::REG_COLOR_FOCAL] = d2c_pkg::COLOR_FOCAL_RST;
			cal[d2c_pkg::REG_COLOR_CENTER] = d2c_pkg::COLOR_CENTER_RST;
			cal[d2c_pkg::REG_ROTATION_ROW0] = d2c_pkg::ROTATION_ROW0_RST;
			cal[d2c_pkg::REG_ROTATION_ROW1] = d2c_pkg::ROTATION_ROW1_RST;
			cal[d2c_pkg::REG_ROTATION_ROW2] = d2c_pkg::ROTATION_ROW2_RST;
			cal[d2c_pkg::REG_TRANSLATION] = d2c_pkg::TRANSLATION_RST;
			mismatches = 0;
		endfunction

		function void write_reg(d2c_pkg::reg_index_t idx, logic [47:0] value);
			cal[idx] = (idx <= d2c_pkg::REG_COLOR_CENTER) ? {16'd0, value[31:0]} : value;
		endfunction

		static function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0)
				q--;
			return q;
		endfunction

		static function longint clamp16(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		static function longint unproject(longint pix, longint c, longint f, longint d);
			longint n;
			if (f == 0)
				return 0;
			n = (pix * 16 - c) * d * 16;
			return floor_div(2 * n + f, 2 * f);
		endfunction

		function void note_pixel(d2c_pkg::pixel_t px);
			d2c_pkg::result_t r;
			longint d, p[3], q[3], acc, den, u, v;
			logic [47:0] rrow;
			logic [47:0] dfoc, dctr, cfoc, cctr;
			d = px.depth_mm;
			r = '0;
			dfoc = cal[d2c_pkg::REG_DEPTH_FOCAL];
			dctr = cal[d2c_pkg::REG_DEPTH_CENTER];
			cfoc = cal[d2c_pkg::REG_COLOR_FOCAL];
			cctr = cal[d2c_pkg::REG_COLOR_CENTER];
			if (d != 0) begin
				p[0] = unproject(px.pixel_col, dctr[15:0], dfoc[15:0], d);
				p[1] = unproject(px.pixel_row, dctr[31:16], dfoc[31:16], d);
				p[2] = d * 16;
				for (int i = 0; i < 3; i++) begin
					rrow = cal[d2c_pkg::REG_ROTATION_ROW0 + i];
					acc = 0;
					for (int j = 0; j < 3; j++)
						acc += longint'($signed(rrow[16*j +: 16])) * p[j];
					q[i] = floor_div(acc + 8192, 16384)
						+ longint'($signed(cal[d2c_pkg::REG_TRANSLATION][16*i +: 16]));
				end
				if (q[2] > 0) begin
					den = q[2] * 16;
					u = floor_div(longint'(cfoc[15:0]) * q[0]
						+ longint'(cctr[15:0]) * q[2], den);
					v = floor_div(longint'(cfoc[31:16]) * q[1]
						+ longint'(cctr[31:16]) * q[2], den);
					r.point_valid = 1'b1;
					r.in_color_image = (u >= 0 && u < d2c_pkg::COLOR_WIDTH && v >= 0
						&& v < d2c_pkg::COLOR_HEIGHT);
					r.color_col = 16'(clamp16(u));
					r.color_row = 16'(clamp16(v));
				end
				r.point_x = 16'(clamp16(floor_div(q[0] + 8, 16)));
				r.point_y = 16'(clamp16(floor_div(q[1] + 8, 16)));
				r.point_z = 16'(clamp16(floor_div(q[2] + 8, 16)));
			end
			expected_points.insert(expected_points.size(), r);
		endfunction

		function bit check_point(d2c_pkg::result_t got);
			d2c_pkg::result_t e;
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected point %p", got);
				return 0;
			end
			e = expected_points.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("point mismatch: expected %p got %p", e, got);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	d2c_stream_if #(.T(d2c_pkg::pixel_t)) pixel();
	d2c_stream_if #(.T(d2c_pkg::result_t)) point();
	d2c_cfg_if cfg();

	depth_to_color_registration_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel.sink),
		.point(point.source),
		.cfg(cfg.sink)
	);

	registration_scoreboard sb;
	int idle_cycles;
	bit quiet;
	bit sink_stalls;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		pixel.valid = 0;
		pixel.data = '0;
		point.ready = 0;
		cfg.valid = 0;
		cfg.index = d2c_pkg::REG_DEPTH_FOCAL;
		cfg.data = '0;
	end

	always @(posedge clk) begin
		if ((pixel.valid && pixel.ready) || (point.valid && point.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("depth_to_color_registration_unit_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && point.valid && point.ready)
			void'(sb.check_point(point.data));
	end

	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (quiet || !sink_stalls || $urandom_range(0, 7) != 0) begin
				point.ready <= 1;
			end else begin
				burst = $urandom_range(1, 10);
				point.ready <= 0;
				repeat (burst) @(negedge clk);
				point.ready <= 1;
			end
		end
	end

	task automatic write_cfg(d2c_pkg::reg_index_t idx, logic [47:0] value);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_pixel(logic [8:0] c, logic [8:0] r, logic [15:0] d);
		d2c_pkg::pixel_t px;
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			pixel.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		px.pixel_col = c;
		px.pixel_row = r;
		px.depth_mm = d;
		pixel.valid <= 1;
		pixel.data <= px;
		do @(posedge clk); while (!pixel.ready);
		sb.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic drain();
		pixel.valid <= 0;
		while (sb.expected_points.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_depth();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 20));
			default: return 16'($urandom_range(300, 6000));
		endcase
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	initial begin
		sb = new();
		quiet = 0;
		sink_stalls = 1;
		idle_cycles = 0;
		arst_n = 0;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_pixel(0, 0, 0);
		send_pixel(511, 511, 0);
		send_pixel(0, 0, 1);
		send_pixel(511, 423, 65535);
		send_pixel(511, 511, 65535);
		send_pixel(0, 423, 1000);
		send_pixel(256, 212, 1500);
		send_pixel(255, 256, 32768);
		send_pixel(170, 85, 21845);
		send_pixel(341, 426, 43690);
		send_pixel(0, 511, 500);
		drain();

		// zero depth focal, negative z via translation, extreme color focal
		write_cfg(d2c_pkg::REG_DEPTH_FOCAL, 48'h0);
		write_cfg(d2c_pkg::REG_TRANSLATION, {16'h8000, 16'h7fff, 16'h8000});
		write_cfg(d2c_pkg::REG_COLOR_FOCAL, 48'hffff_ffff);
		send_pixel(100, 100, 100);
		send_pixel(511, 0, 3000);
		send_pixel(5, 400, 65535);
		send_pixel(0, 0, 1);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			write_cfg(d2c_pkg::REG_DEPTH_FOCAL, phase == 0 ? 48'hffff_ffff
				: phase == 1 ? 48'h0001_0001 : rand48());
			write_cfg(d2c_pkg::REG_DEPTH_CENTER, phase == 0 ? 48'hffff_ffff
				: phase == 1 ? 48'h0 : rand48());
			write_cfg(d2c_pkg::REG_COLOR_FOCAL, phase == 1 ? 48'h0 : rand48());
			write_cfg(d2c_pkg::REG_COLOR_CENTER, phase == 0 ? 48'hffff_ffff : rand48());
			write_cfg(d2c_pkg::REG_ROTATION_ROW0, phase == 0 ? 48'hffff_ffff_ffff
				: phase == 1 ? 48'h8000_8000_8000 : rand48());
			write_cfg(d2c_pkg::REG_ROTATION_ROW1,
				phase == 0 ? 48'h7fff_7fff_7fff : rand48());
			write_cfg(d2c_pkg::REG_ROTATION_ROW2,
				phase == 1 ? 48'h7fff_7fff_7fff : rand48());
			write_cfg(d2c_pkg::REG_TRANSLATION,
				phase == 0 ? 48'h7fff_7fff_7fff : rand48());
			repeat (60)
				send_pixel(9'($urandom), 9'($urandom), rand_depth());
			drain();
		end

		// back to the nominal calibration for the bulk of the run
		write_cfg(d2c_pkg::REG_DEPTH_FOCAL, d2c_pkg::DEPTH_FOCAL_RST);
		write_cfg(d2c_pkg::REG_DEPTH_CENTER, d2c_pkg::DEPTH_CENTER_RST);
		write_cfg(d2c_pkg::REG_COLOR_FOCAL, d2c_pkg::COLOR_FOCAL_RST);
		write_cfg(d2c_pkg::REG_COLOR_CENTER, d2c_pkg::COLOR_CENTER_RST);
		write_cfg(d2c_pkg::REG_ROTATION_ROW0, d2c_pkg::ROTATION_ROW0_RST);
		write_cfg(d2c_pkg::REG_ROTATION_ROW1, d2c_pkg::ROTATION_ROW1_RST);
		write_cfg(d2c_pkg::REG_ROTATION_ROW2, d2c_pkg::ROTATION_ROW2_RST);
		write_cfg(d2c_pkg::REG_TRANSLATION, d2c_pkg::TRANSLATION_RST);
		for (int i = 0; i < 1000; i++)
			send_pixel(9'($urandom_range(0, 511)), 9'($urandom_range(0, 423)),
				rand_depth());
		drain();

		quiet = 1;
		sink_stalls = 0;
		for (int i = 0; i < 300; i++)
			send_pixel(9'($urandom), 9'($urandom), rand_depth());
		drain();

		if (sb.mismatches == 0 && sb.expected_points.size() == 0)
			$display("depth_to_color_registration_unit_tb OK");
		else
			$display("depth_to_color_registration_unit_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
src/d2c_pkg.sv
src/d2c_stream_if.sv
src/d2c_cfg_if.sv
src/d2c_floor_div.sv
src/depth_to_color_registration_unit.sv
test/depth_to_color_registration_unit_tb.sv
